/* rtl/spos_pkg.sv */
// spos_pkg: shared constants and codes for the shadow pair overlap scan.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package spos_pkg;

    localparam int MAX_CASTERS_DEF   = 64;
    localparam int MAX_RECEIVERS_DEF = 64;
    localparam int MAX_SHADOWS_DEF   = 16;
    localparam int COORD_BITS_DEF    = 24;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_LOAD_CASTER   = 2'd0;
    localparam t_mode MODE_LOAD_RECEIVER = 2'd1;
    localparam t_mode MODE_CLEAR         = 2'd2;
    localparam t_mode MODE_SCAN          = 2'd3;

endpackage

`default_nettype wire

/* rtl/spos_if.sv */
// spos_if: valid/ready channels for box words in and shadow words out.
// Depends on spos_pkg for the mode type and default coordinate width.
`default_nettype none

interface spos_in_if #(
    parameter int COORD_BITS = spos_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    spos_pkg::t_mode              mode;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [COORD_BITS-1:0] half_x;
    logic signed [COORD_BITS-1:0] half_y;
    logic signed [COORD_BITS-1:0] half_z;

    modport source (output valid, mode, pos_x, pos_y, pos_z, half_x, half_y, half_z,
                    input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pos_z, half_x, half_y, half_z,
                    output ready);
endinterface

interface spos_out_if #(
    parameter int COORD_BITS = spos_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic signed [COORD_BITS-1:0] shadow_x;
    logic signed [COORD_BITS:0]   shadow_y;
    logic signed [COORD_BITS-1:0] shadow_z;
    logic signed [COORD_BITS-1:0] scale_x;
    logic signed [COORD_BITS-1:0] scale_z;
    logic                         last;

    modport source (output valid, found, shadow_x, shadow_y, shadow_z, scale_x, scale_z,
                    last, input ready);
    modport sink   (input valid, found, shadow_x, shadow_y, shadow_z, scale_x, scale_z,
                    last, output ready);
endinterface

`default_nettype wire

/* rtl/shadow_pair_overlap_scan_top.sv */
// shadow_pair_overlap_scan_top: caster/receiver box lists in two RAMs and the pair scan.
// Depends on spos_pkg and the spos_in_if / spos_out_if channels.
//
//   channel   dir  word                                   handshake
//   i_in      in   mode, pos_x/y/z, half_x/y/z            valid/ready
//   o_out     out  found, shadow_x/y/z, scale_x/z, last   valid/ready
//
// Load and clear words are taken while idle. A scan is accepted; for each caster it reads
// the caster, tries receivers in turn and emits a shadow on a hit; then it closes. The
// receiver RAM read port sets the one-pair-per-cycle pace, paused at caster reads and hits.
// The last shadow is held back one step so it can carry last. A full output register
// stalls the scan at a hit with a shadow already held, or at its close.
// No clearing pass after reset.
`default_nettype none

module shadow_pair_overlap_scan_top #(
    parameter int MAX_CASTERS   = spos_pkg::MAX_CASTERS_DEF,
    parameter int MAX_RECEIVERS = spos_pkg::MAX_RECEIVERS_DEF,
    parameter int MAX_SHADOWS   = spos_pkg::MAX_SHADOWS_DEF,
    parameter int COORD_BITS    = spos_pkg::COORD_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    spos_in_if.sink     i_in,
    spos_out_if.source  o_out
);

    localparam int CB   = COORD_BITS;
    localparam int BW   = 6 * CB;
    localparam int CIW  = (MAX_CASTERS > 1) ? $clog2(MAX_CASTERS) : 1;
    localparam int RIW  = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;
    localparam int CCW  = $clog2(MAX_CASTERS + 1);
    localparam int RCW  = $clog2(MAX_RECEIVERS + 1);
    localparam int SCW  = $clog2(MAX_SHADOWS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CRD  = 3'd1;
    localparam logic [2:0] S_CLAT = 3'd2;
    localparam logic [2:0] S_RCHK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // box RAMs, packed {hz, hy, hx, pz, py, px}
    logic [BW-1:0] cast_mem [MAX_CASTERS];
    logic [BW-1:0] recv_mem [MAX_RECEIVERS];
    logic [BW-1:0] c_q, r_q;
    logic [CIW-1:0] c_raddr;
    logic [RIW-1:0] r_raddr;

    logic [2:0]     r_state, n_state;
    logic [CCW-1:0] r_ccount, n_ccount;
    logic [RCW-1:0] r_rcount, n_rcount;
    logic [CIW-1:0] r_ci, n_ci;
    logic [RIW-1:0] r_ri, n_ri;
    logic [SCW-1:0] r_nsh, n_nsh;
    logic           r_pend_v, n_pend_v;
    logic           r_ov, n_ov;

    // latched caster bounds
    logic signed [CB:0]   r_cxlo, r_cxhi, r_czlo, r_czhi, r_ctop;
    logic signed [CB-1:0] r_cpx, r_cpz, r_chx, r_chz;
    // current hit, held-back shadow, output register
    logic signed [CB:0]   r_hy, r_py, r_oy;
    logic signed [CB-1:0] r_hpx, r_hpz, r_hhx, r_hhz;
    logic signed [CB-1:0] r_ppx, r_ppz, r_phx, r_phz;
    logic signed [CB-1:0] r_opx, r_opz, r_ohx, r_ohz;
    logic                 r_ofound, r_olast;

    logic in_acc, box_we_c, box_we_r, out_free;
    logic ld_hit, ld_pend, ld_out, out_pend, out_last;
    logic last_c, last_r;
    logic [BW-1:0] in_box;

    logic signed [CB-1:0] cq_px, cq_py, cq_pz, cq_hx, cq_hy, cq_hz;
    logic signed [CB-1:0] rq_px, rq_py, rq_pz, rq_hx, rq_hy, rq_hz;
    logic signed [CB:0]   rxlo, rxhi, rzlo, rzhi, rtop;
    logic                 hit;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_box   = {i_in.half_z, i_in.half_y, i_in.half_x, i_in.pos_z, i_in.pos_y,
                       i_in.pos_x};
    assign box_we_c = in_acc && (i_in.mode == spos_pkg::MODE_LOAD_CASTER)
                      && (r_ccount < CCW'(MAX_CASTERS));
    assign box_we_r = in_acc && (i_in.mode == spos_pkg::MODE_LOAD_RECEIVER)
                      && (r_rcount < RCW'(MAX_RECEIVERS));
    assign out_free = !r_ov || o_out.ready;

    assign c_raddr = r_ci;
    assign r_raddr = (r_state == S_RCHK) ? r_ri + RIW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (box_we_c) begin
            cast_mem[r_ccount[CIW-1:0]] <= in_box;
        end
        c_q <= cast_mem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (box_we_r) begin
            recv_mem[r_rcount[RIW-1:0]] <= in_box;
        end
        r_q <= recv_mem[r_raddr];
    end

    assign {cq_hz, cq_hy, cq_hx, cq_pz, cq_py, cq_px} = c_q;
    assign {rq_hz, rq_hy, rq_hx, rq_pz, rq_py, rq_px} = r_q;

    assign rxlo = $signed({rq_px[CB-1], rq_px}) - $signed({rq_hx[CB-1], rq_hx});
    assign rxhi = $signed({rq_px[CB-1], rq_px}) + $signed({rq_hx[CB-1], rq_hx});
    assign rzlo = $signed({rq_pz[CB-1], rq_pz}) - $signed({rq_hz[CB-1], rq_hz});
    assign rzhi = $signed({rq_pz[CB-1], rq_pz}) + $signed({rq_hz[CB-1], rq_hz});
    assign rtop = $signed({rq_py[CB-1], rq_py}) + $signed({rq_hy[CB-1], rq_hy});

    assign hit = (r_cxhi >= rxlo) && (r_cxlo <= rxhi) && (r_czhi >= rzlo)
                 && (r_czlo <= rzhi) && (r_ctop >= rtop);

    assign last_c = (CCW'(r_ci) + CCW'(1)) == r_ccount;
    assign last_r = (RCW'(r_ri) + RCW'(1)) == r_rcount;

    always_comb begin
        n_state  = r_state;
        n_ccount = r_ccount;
        n_rcount = r_rcount;
        n_ci     = r_ci;
        n_ri     = r_ri;
        n_nsh    = r_nsh;
        n_pend_v = r_pend_v;
        ld_hit   = 1'b0;
        ld_pend  = 1'b0;
        ld_out   = 1'b0;
        out_pend = 1'b0;
        out_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.mode)
                        spos_pkg::MODE_LOAD_CASTER: begin
                            if (box_we_c) n_ccount = r_ccount + CCW'(1);
                        end
                        spos_pkg::MODE_LOAD_RECEIVER: begin
                            if (box_we_r) n_rcount = r_rcount + RCW'(1);
                        end
                        spos_pkg::MODE_CLEAR: begin
                            n_ccount = '0;
                            n_rcount = '0;
                        end
                        default: begin
                            n_ci     = '0;
                            n_nsh    = '0;
                            n_pend_v = 1'b0;
                            if (r_ccount == '0 || r_rcount == '0) n_state = S_FIN;
                            else                                  n_state = S_CRD;
                        end
                    endcase
                end
            end
            S_CRD: n_state = S_CLAT;
            S_CLAT: begin
                n_ri    = '0;
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (hit) begin
                    ld_hit  = 1'b1;
                    n_state = S_EMIT;
                end else if (!last_r) begin
                    n_ri = r_ri + RIW'(1);
                end else if (last_c) begin
                    n_state = S_FIN;
                end else begin
                    n_ci    = r_ci + CIW'(1);
                    n_state = S_CRD;
                end
            end
            S_EMIT: begin
                if (!r_pend_v || out_free) begin
                    ld_pend  = 1'b1;
                    ld_out   = r_pend_v;
                    out_pend = 1'b1;
                    n_pend_v = 1'b1;
                    n_nsh    = r_nsh + SCW'(1);
                    if ((r_nsh + SCW'(1)) == SCW'(MAX_SHADOWS) || last_c) begin
                        n_state = S_FIN;
                    end else begin
                        n_ci    = r_ci + CIW'(1);
                        n_state = S_CRD;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    ld_out   = 1'b1;
                    out_pend = r_pend_v;
                    out_last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (ld_out)           n_ov = 1'b1;
        else if (o_out.ready) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ccount <= '0;
            r_rcount <= '0;
            r_ci     <= '0;
            r_ri     <= '0;
            r_nsh    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ccount <= n_ccount;
            r_rcount <= n_rcount;
            r_ci     <= n_ci;
            r_ri     <= n_ri;
            r_nsh    <= n_nsh;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLAT) begin
            r_cxlo <= $signed({cq_px[CB-1], cq_px}) - $signed({cq_hx[CB-1], cq_hx});
            r_cxhi <= $signed({cq_px[CB-1], cq_px}) + $signed({cq_hx[CB-1], cq_hx});
            r_czlo <= $signed({cq_pz[CB-1], cq_pz}) - $signed({cq_hz[CB-1], cq_hz});
            r_czhi <= $signed({cq_pz[CB-1], cq_pz}) + $signed({cq_hz[CB-1], cq_hz});
            r_ctop <= $signed({cq_py[CB-1], cq_py}) + $signed({cq_hy[CB-1], cq_hy});
            r_cpx  <= cq_px;
            r_cpz  <= cq_pz;
            r_chx  <= cq_hx;
            r_chz  <= cq_hz;
        end
        if (ld_hit) begin
            r_hy  <= rtop;
            r_hpx <= r_cpx;
            r_hpz <= r_cpz;
            r_hhx <= r_chx;
            r_hhz <= r_chz;
        end
        if (ld_pend) begin
            r_py  <= r_hy;
            r_ppx <= r_hpx;
            r_ppz <= r_hpz;
            r_phx <= r_hhx;
            r_phz <= r_hhz;
        end
        if (ld_out) begin
            r_ofound <= out_pend;
            r_olast  <= out_last;
            r_oy     <= out_pend ? r_py  : '0;
            r_opx    <= out_pend ? r_ppx : '0;
            r_opz    <= out_pend ? r_ppz : '0;
            r_ohx    <= out_pend ? r_phx : '0;
            r_ohz    <= out_pend ? r_phz : '0;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.found    = r_ofound;
    assign o_out.shadow_x = r_opx;
    assign o_out.shadow_y = r_oy;
    assign o_out.shadow_z = r_opz;
    assign o_out.scale_x  = r_ohx;
    assign o_out.scale_z  = r_ohz;
    assign o_out.last     = r_olast;

    a_ccount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccount <= CCW'(MAX_CASTERS))
        else $error("caster count beyond capacity");

    a_nsh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nsh <= SCW'(MAX_SHADOWS))
        else $error("shadow count beyond limit");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state != S_IDLE))
        else $error("held shadow left over after scan");

    a_nofound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ofound) |-> r_olast)
        else $error("empty result word not marked last");

    a_scan_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == spos_pkg::MODE_SCAN) |=> (r_state != S_IDLE))
        else $error("scan word did not start a scan");

    a_no_ram_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !(box_we_c || box_we_r))
        else $error("box RAM written during scan");

endmodule

`default_nettype wire
